>>> src/mbe_pkg.sv
// Shared types, widths, reset values and helpers for the escape-time evaluator.
// No dependencies; every other file in src imports this package.
`default_nettype none

package mbe_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 24;
  localparam int PIX_W     = 12;
  localparam int ITER_W    = 16;
  localparam int STEP_W    = 31;
  localparam int RADIUS_W  = 31;

  // Datapath widths
  localparam int PROD_W = PIX_W + 1 + STEP_W + 1;   // pixel offset times step
  localparam int SUM_W  = 48;                       // widest sum ahead of saturation
  localparam int SQ_W   = 2 * COORD_W;              // full square or cross product
  localparam int MAG_W  = SQ_W - FRAC_BITS;         // floored squared magnitude

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register reset values
  localparam logic [STEP_W-1:0]   RST_STEP      = STEP_W'(62915);
  localparam logic [COORD_W-1:0]  RST_SHIFT     = '0;
  localparam logic [PIX_W-1:0]    RST_MID_X     = PIX_W'(400);
  localparam logic [PIX_W-1:0]    RST_MID_Y     = PIX_W'(300);
  localparam logic [ITER_W-1:0]   RST_MAX_ITER  = ITER_W'(256);
  localparam logic [RADIUS_W-1:0] RST_RADIUS_SQ = RADIUS_W'(1677721600);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_X,
    REG_STEP_Y,
    REG_SHIFT_X,
    REG_SHIFT_Y,
    REG_MID_X,
    REG_MID_Y,
    REG_MAX_ITER,
    REG_RADIUS_SQ
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [COORD_W-1:0]  shift_x;
    logic [COORD_W-1:0]  shift_y;
    logic [PIX_W-1:0]    mid_x;
    logic [PIX_W-1:0]    mid_y;
    logic [ITER_W-1:0]   max_iter;
    logic [RADIUS_W-1:0] radius_sq;
  } cfg_t;

  // One mapped pixel on its way to the iteration engine
  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COORD_W-1:0] c_real;
    logic [COORD_W-1:0] c_imag;
  } job_t;

  // Clamp a wide signed sum to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    logic [COORD_W-1:0]     r;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mbe_front.sv
// Front end: accepts pixels and maps each one to its point c in the plane.
// Depends on mbe_pkg; feeds the job queue.
`default_nettype none

module mbe_front
  import mbe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             pix_valid,
  output logic                  pix_stall,
  input  wire logic [PIX_W-1:0] pixel_x,
  input  wire logic [PIX_W-1:0] pixel_y,
  output logic                  push,
  output job_t                  wdata,
  input  wire logic             full
);

  logic                       s1_valid;
  logic                       s1_ready;
  logic [PIX_W-1:0]           s1_px;
  logic [PIX_W-1:0]           s1_py;
  logic signed [PROD_W-1:0]   s1_prod_x;
  logic signed [PROD_W-1:0]   s1_prod_y;
  logic signed [PIX_W:0]      dx;
  logic signed [PIX_W:0]      dy;
  logic signed [PROD_W-1:0]   prod_x;
  logic signed [PROD_W-1:0]   prod_y;

  // Offset from the middle pixel, scaled by the step
  assign dx     = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.mid_x});
  assign dy     = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.mid_y});
  assign prod_x = dx * $signed({1'b0, cfg.step_x});
  assign prod_y = dy * $signed({1'b0, cfg.step_y});

  // Advance when the stage is empty or hands its item to the queue
  assign push      = s1_valid && !full;
  assign s1_ready  = !s1_valid || !full;
  assign pix_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pix_valid;
    end
    if (s1_ready && pix_valid) begin
      s1_px     <= pixel_x;
      s1_py     <= pixel_y;
      s1_prod_x <= prod_x;
      s1_prod_y <= prod_y;
    end
  end

  // Add the plane shift and clamp
  always_comb begin
    wdata.px     = s1_px;
    wdata.py     = s1_py;
    wdata.c_real = sat_coord(SUM_W'(s1_prod_x) + SUM_W'($signed(cfg.shift_x)));
    wdata.c_imag = sat_coord(SUM_W'(s1_prod_y) + SUM_W'($signed(cfg.shift_y)));
  end

endmodule

`default_nettype wire

>>> src/mbe_fifo.sv
// Short job queue that lets the front end and the iteration engine stall apart.
// Depends on mbe_pkg for the job type and depth.
`default_nettype none

module mbe_fifo
  import mbe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);

  job_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job queue read while empty");
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("job queue fill level did not rise on a lone write");

endmodule

`default_nettype wire

>>> src/mbe_iter.sv
// Back end: iterates z = z*z + c for one job at a time and holds the result.
// Depends on mbe_pkg; takes jobs from the queue.
`default_nettype none

module mbe_iter
  import mbe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [ITER_W-1:0]   max_iter,
  input  wire logic [RADIUS_W-1:0] radius_sq,
  input  wire job_t                rdata,
  input  wire logic                empty,
  output logic                     pop,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output logic [PIX_W-1:0]         out_x,
  output logic [PIX_W-1:0]         out_y,
  output logic [ITER_W-1:0]        iter_count,
  output logic                     escaped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD
  } state_t;

  state_t                     state;
  logic signed [COORD_W-1:0]  zr;
  logic signed [COORD_W-1:0]  zi;
  logic signed [COORD_W-1:0]  cr;
  logic signed [COORD_W-1:0]  ci;
  logic [PIX_W-1:0]           px;
  logic [PIX_W-1:0]           py;
  logic [ITER_W-1:0]          k;
  logic signed [SQ_W-1:0]     sq_r;
  logic signed [SQ_W-1:0]     sq_i;
  logic signed [SQ_W-1:0]     p_ri;
  logic signed [SQ_W-1:0]     diff;
  logic [SQ_W-1:0]            mag_sum;
  logic [MAG_W-1:0]           mag;
  logic [COORD_W-1:0]         nr;
  logic [COORD_W-1:0]         ni;
  logic                       esc;
  logic                       finish;
  logic                       slot_free;
  logic                       res_load;

  // Escape test on the current z (not on the starting point) and next z
  assign mag_sum   = $unsigned(sq_r) + $unsigned(sq_i);
  assign mag       = mag_sum[SQ_W-1:FRAC_BITS];
  assign esc       = (k != '0) && (mag > MAG_W'(radius_sq));
  assign finish    = esc || (k == max_iter);
  assign diff      = sq_r - sq_i;
  assign nr        = sat_coord(SUM_W'($signed(diff[SQ_W-1:FRAC_BITS])) + SUM_W'(cr));
  assign ni        = sat_coord(SUM_W'($signed(p_ri[SQ_W-1:FRAC_BITS-1])) + SUM_W'(ci));
  assign slot_free = !res_valid || !res_stall;
  assign res_load  = (state == ST_ADD) && finish && slot_free;
  assign pop       = (state == ST_IDLE) && !empty;

  // Sequence one job: load, then alternate multiply and update until done
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      // Raise the result on a finished job, drop it once taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            px    <= rdata.px;
            py    <= rdata.py;
            cr    <= $signed(rdata.c_real);
            ci    <= $signed(rdata.c_imag);
            zr    <= $signed(rdata.c_real);
            zi    <= $signed(rdata.c_imag);
            k     <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          sq_r  <= zr * zr;
          sq_i  <= zi * zi;
          p_ri  <= zr * zi;
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (finish) begin
            // Hold here until the result register frees up
            if (slot_free) begin
              out_x      <= px;
              out_y      <= py;
              iter_count <= esc ? (k - 1'b1) : k;
              escaped    <= esc;
              state      <= ST_IDLE;
            end
          end else begin
            zr    <= $signed(nr);
            zi    <= $signed(ni);
            k     <= k + 1'b1;
            state <= ST_MUL;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
      (state != ST_IDLE) |-> (k <= max_iter))
    else $error("update count ran past the limit");
  a_step: assert property (@(posedge clk) disable iff (rst)
      (state == ST_ADD && !finish) |=> (state == ST_MUL && k == $past(k) + 1'b1))
    else $error("update step did not advance the count");
  a_esc_count: assert property (@(posedge clk) disable iff (rst)
      (res_valid && escaped) |-> (iter_count < max_iter))
    else $error("escaped result with count at or past the limit");
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
      (res_valid && !escaped) |-> (iter_count == max_iter))
    else $error("bounded result without the limit as count");

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: register file, front end, queue, engine.
// Depends on mbe_pkg, mbe_front, mbe_fifo and mbe_iter.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   pixel in | pix_valid / pix_stall   | pixel_x, pixel_y
//   result   | res_valid / res_stall   | out_x, out_y, iter_count, escaped
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A pixel whose job performs n updates (n <= max_iter) passes the front stage, waits at
// the queue head while the engine loads it, and then runs the multiply/update loop,
// once per update and once more to end the job, before it is presented as a result.
// The engine works on one job at a time and loads the next only from idle. The front stage
// and the two-entry queue keep taking pixels while the engine is busy. Reset loads
// the register defaults and empties every stage. A stalled result holds the engine
// in its last step.
`default_nettype none

module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output logic                       pix_stall,
  input  wire logic [PIX_W-1:0]      pixel_x,
  input  wire logic [PIX_W-1:0]      pixel_y,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic [PIX_W-1:0]           out_x,
  output logic [PIX_W-1:0]           out_y,
  output logic [ITER_W-1:0]          iter_count,
  output logic                       escaped,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t wdata;
  job_t rdata;

  assign cfg_ready = 1'b1;

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_x    <= RST_STEP;
      cfg.step_y    <= RST_STEP;
      cfg.shift_x   <= RST_SHIFT;
      cfg.shift_y   <= RST_SHIFT;
      cfg.mid_x     <= RST_MID_X;
      cfg.mid_y     <= RST_MID_Y;
      cfg.max_iter  <= RST_MAX_ITER;
      cfg.radius_sq <= RST_RADIUS_SQ;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_STEP_X:    cfg.step_x    <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:    cfg.step_y    <= cfg_data[STEP_W-1:0];
        REG_SHIFT_X:   cfg.shift_x   <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Y:   cfg.shift_y   <= cfg_data[COORD_W-1:0];
        REG_MID_X:     cfg.mid_x     <= cfg_data[PIX_W-1:0];
        REG_MID_Y:     cfg.mid_y     <= cfg_data[PIX_W-1:0];
        REG_MAX_ITER:  cfg.max_iter  <= cfg_data[ITER_W-1:0];
        REG_RADIUS_SQ: cfg.radius_sq <= cfg_data[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .push      (push),
    .wdata     (wdata),
    .full      (full)
  );

  mbe_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  mbe_iter u_iter (
    .clk        (clk),
    .rst        (rst),
    .max_iter   (cfg.max_iter),
    .radius_sq  (cfg.radius_sq),
    .rdata      (rdata),
    .empty      (empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .iter_count (iter_count),
    .escaped    (escaped)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for mandelbrot_escape_time: directed table, then random views.
// Depends on mbe_pkg and the RTL in src; a local escape-time predictor checks every item.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbe_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint COORD_MAX    = 64'sd2147483647;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam int     RANDOM_ITEMS = 650;
  localparam int     LONG_HOLD    = 600;
  localparam int     SETTLE_CYCLES = 32;
  localparam longint CYCLE_LIMIT  = 10_000_000;
  // Pixel offset that keeps c within about 2.5 of the shift
  localparam int     VIEW_REACH   = 41943040;

  // One pixel result as the block reports it
  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [ITER_W-1:0] iters;
    logic              esc;
  } escape_t;

  // Raw register words, upper bits beyond a field's width included
  typedef struct packed {
    logic [CFG_DATA_W-1:0] step_x;
    logic [CFG_DATA_W-1:0] step_y;
    logic [CFG_DATA_W-1:0] shift_x;
    logic [CFG_DATA_W-1:0] shift_y;
    logic [CFG_DATA_W-1:0] mid_x;
    logic [CFG_DATA_W-1:0] mid_y;
    logic [CFG_DATA_W-1:0] max_iter;
    logic [CFG_DATA_W-1:0] radius_sq;
  } plane_cfg_t;

  typedef struct packed {
    logic [2:0]        cfg_sel;
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic              known;
    logic [ITER_W-1:0] iters;
    logic              esc;
  } dir_row_t;

  localparam int NUM_DIR_CFG  = 6;
  localparam int NUM_DIR_ROWS = 20;

  // Views for the directed rows; view 0 is the state after reset and is never written
  localparam plane_cfg_t DIR_CFG [NUM_DIR_CFG] = '{
    '{32'd62915, 32'd62915, 32'h0, 32'h0, 32'd400, 32'd300, 32'd256, 32'd1677721600},
    // zero iteration limit, hidden under junk in the upper half
    '{32'd62915, 32'd62915, 32'h0, 32'h0, 32'd400, 32'd300, 32'hABCD_0000,
      32'd1677721600},
    // largest step and shifts: c saturates both ways
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
      32'h0000_0001, 32'hFFFF_FFFF},
    // c pinned at zero, largest limit, zero radius
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF, 32'h0},
    // c = -2: |z|^2 sits exactly on a radius of 4
    '{32'h0, 32'h0, 32'hFE00_0000, 32'h0, 32'h0, 32'h0, 32'd300, 32'h0400_0000},
    // usual view shifted left by eight, junk above the field widths
    '{32'h8000_F5C3, 32'h0000_F5C3, 32'hF800_0000, 32'h0, 32'hFFFF_F190, 32'h0000_012C,
      32'hFFFF_0040, 32'h0400_0000}
  };

  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    '{3'd0, 12'd400,  12'd300,  1'b1, 16'd256,   1'b0},
    '{3'd0, 12'd0,    12'd0,    1'b0, 16'd0,     1'b0},
    '{3'd0, 12'd4095, 12'd4095, 1'b0, 16'd0,     1'b0},
    '{3'd0, 12'd200,  12'd150,  1'b0, 16'd0,     1'b0},
    '{3'd0, 12'd0,    12'd4095, 1'b0, 16'd0,     1'b0},
    '{3'd1, 12'd400,  12'd300,  1'b1, 16'd0,     1'b0},
    '{3'd1, 12'd4095, 12'd0,    1'b1, 16'd0,     1'b0},
    '{3'd2, 12'd4095, 12'd0,    1'b1, 16'd0,     1'b1},
    '{3'd2, 12'd0,    12'd4095, 1'b1, 16'd0,     1'b1},
    '{3'd2, 12'd4095, 12'd4095, 1'b0, 16'd0,     1'b0},
    '{3'd2, 12'd0,    12'd0,    1'b0, 16'd0,     1'b0},
    '{3'd3, 12'd2048, 12'd2048, 1'b1, 16'd65535, 1'b0},
    '{3'd4, 12'd0,    12'd0,    1'b0, 16'd0,     1'b0},
    '{3'd5, 12'd400,  12'd300,  1'b0, 16'd0,     1'b0},
    '{3'd5, 12'd0,    12'd0,    1'b0, 16'd0,     1'b0},
    '{3'd5, 12'd4095, 12'd4095, 1'b0, 16'd0,     1'b0},
    '{3'd5, 12'hAAB,  12'h555,  1'b0, 16'd0,     1'b0},
    '{3'd5, 12'h555,  12'hAAA,  1'b0, 16'd0,     1'b0},
    '{3'd5, 12'd520,  12'd300,  1'b0, 16'd0,     1'b0},
    '{3'd5, 12'd350,  12'd350,  1'b0, 16'd0,     1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  logic [PIX_W-1:0]      pixel_x = '0;
  logic [PIX_W-1:0]      pixel_y = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [PIX_W-1:0]      out_x;
  logic [PIX_W-1:0]      out_y;
  logic [ITER_W-1:0]     iter_count;
  logic                  escaped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = REG_STEP_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor's copy of the register file
  logic [STEP_W-1:0]          cur_step_x = RST_STEP;
  logic [STEP_W-1:0]          cur_step_y = RST_STEP;
  logic signed [COORD_W-1:0]  cur_shift_x = RST_SHIFT;
  logic signed [COORD_W-1:0]  cur_shift_y = RST_SHIFT;
  logic [PIX_W-1:0]           cur_mid_x = RST_MID_X;
  logic [PIX_W-1:0]           cur_mid_y = RST_MID_Y;
  logic [ITER_W-1:0]          cur_max_iter = RST_MAX_ITER;
  logic [RADIUS_W-1:0]        cur_radius_sq = RST_RADIUS_SQ;

  escape_t pending_escapes[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    hold_arm = 1'b0;
  logic    hold_arm_q = 1'b0;
  int      hold_left = 0;
  longint  cycles = 0;

  mandelbrot_escape_time dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .iter_count (iter_count),
    .escaped    (escaped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp to the signed coordinate range
  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // Map the pixel to c, iterate z = z^2 + c, report the escape step or the limit
  function automatic escape_t predict_escape(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint      cr, ci, zr, zi, nr, ni;
    u64_t        mag;
    int unsigned k;
    logic        esc;
    escape_t     r;
    cr = clamp_coord((longint'(px) - longint'(cur_mid_x)) * longint'(cur_step_x)
                     + longint'(cur_shift_x));
    ci = clamp_coord((longint'(py) - longint'(cur_mid_y)) * longint'(cur_step_y)
                     + longint'(cur_shift_y));
    zr = cr;
    zi = ci;
    k = 0;
    esc = 1'b0;
    while (k < cur_max_iter && !esc) begin
      nr = clamp_coord(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clamp_coord(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = (u64_t'(zr * zr) + u64_t'(zi * zi)) >> FRAC_BITS;
      if (mag > u64_t'(cur_radius_sq)) esc = 1'b1;
      else k++;
    end
    r.x = px;
    r.y = py;
    r.iters = ITER_W'(k);
    r.esc = esc;
    return r;
  endfunction

  // Random view: mostly a window of about +-2.5 around a random shift
  function automatic plane_cfg_t random_plane();
    plane_cfg_t p;
    int         pick;
    p.step_x = ($urandom_range(9) == 0) ? $urandom
             : {1'($urandom_range(1)), 31'($urandom_range(524288, 1024))};
    p.step_y = ($urandom_range(9) == 0) ? $urandom
             : {1'($urandom_range(1)), 31'($urandom_range(524288, 1024))};
    p.shift_x = ($urandom_range(9) == 0) ? $urandom
              : 32'($urandom_range(2 * VIEW_REACH)) - 32'(VIEW_REACH);
    p.shift_y = ($urandom_range(9) == 0) ? $urandom
              : 32'($urandom_range(2 * VIEW_REACH)) - 32'(VIEW_REACH);
    p.mid_x = $urandom;
    p.mid_y = $urandom;
    pick = $urandom_range(19);
    if (pick < 16) p.max_iter = {16'($urandom), 16'($urandom_range(128, 1))};
    else if (pick < 19) p.max_iter = {16'($urandom), 16'($urandom_range(1024, 129))};
    else p.max_iter = {16'($urandom), 16'($urandom_range(1))};
    case ($urandom_range(3))
      0: p.radius_sq = 32'h0400_0000;
      1: p.radius_sq = $urandom;
      2: p.radius_sq = $urandom_range(32'h1000_0000);
      default: p.radius_sq = 32'h0400_0000 + $urandom_range(255) - 128;
    endcase
    return p;
  endfunction

  // Pixel near the centre of the view, now and then anywhere
  function automatic logic [PIX_W-1:0] near_pixel(logic [PIX_W-1:0] mid,
                                                  logic [STEP_W-1:0] step);
    int span;
    span = (step == 0) ? 2047 : int'(VIEW_REACH / step) + 1;
    if (span > 2047) span = 2047;
    if ($urandom_range(4) == 0) return PIX_W'($urandom);
    return PIX_W'(int'(mid) + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // mirror the write, dropping bits above each field
    case (idx)
      REG_STEP_X:    cur_step_x = data[STEP_W-1:0];
      REG_STEP_Y:    cur_step_y = data[STEP_W-1:0];
      REG_SHIFT_X:   cur_shift_x = data;
      REG_SHIFT_Y:   cur_shift_y = data;
      REG_MID_X:     cur_mid_x = data[PIX_W-1:0];
      REG_MID_Y:     cur_mid_y = data[PIX_W-1:0];
      REG_MAX_ITER:  cur_max_iter = data[ITER_W-1:0];
      REG_RADIUS_SQ: cur_radius_sq = data[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_plane(plane_cfg_t p);
    write_reg(REG_STEP_X, p.step_x);
    write_reg(REG_STEP_Y, p.step_y);
    write_reg(REG_SHIFT_X, p.shift_x);
    write_reg(REG_SHIFT_Y, p.shift_y);
    write_reg(REG_MID_X, p.mid_x);
    write_reg(REG_MID_Y, p.mid_y);
    write_reg(REG_MAX_ITER, p.max_iter);
    write_reg(REG_RADIUS_SQ, p.radius_sq);
    cfg_valid <= 1'b0;
  endtask

  // Hold the pixel side idle until every pending escape is back
  task automatic wait_for_results();
    pix_valid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
  endtask

  // Offer one pixel after a random gap; queue its expected result on acceptance
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, logic known,
                            logic [ITER_W-1:0] iters, logic esc);
    escape_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (pix_stall);
    if (known) want = '{px, py, iters, esc};
    else want = predict_escape(px, py);
    pending_escapes.push_back(want);
  endtask

  task automatic check_field(string name, logic [ITER_W-1:0] want, logic [ITER_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stall, plus one long hold-off when armed
  always @(posedge clk) begin
    hold_arm_q <= hold_arm;
    if (hold_arm && !hold_arm_q) hold_left = LONG_HOLD;
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest pending escape
  always @(posedge clk) begin : result_check
    escape_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_escapes.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d iter=%0d esc=%0b", $time,
                 out_x, out_y, iter_count, escaped);
        mismatches++;
      end else begin
        want = pending_escapes.pop_front();
        check_field("out_x", ITER_W'(want.x), ITER_W'(out_x));
        check_field("out_y", ITER_W'(want.y), ITER_W'(out_y));
        check_field("iter_count", want.iters, iter_count);
        check_field("escaped", ITER_W'(want.esc), ITER_W'(escaped));
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("mandelbrot_escape_time: mismatch");
    $finish;
  end

  initial begin : stimulus
    int cur_sel;
    int sent;
    int n;
    cur_sel = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table, switching views only when idle
    for (int i = 0; i < NUM_DIR_ROWS; i++) begin
      if (int'(DIR_ROWS[i].cfg_sel) != cur_sel) begin
        wait_for_results();
        load_plane(DIR_CFG[DIR_ROWS[i].cfg_sel]);
        cur_sel = int'(DIR_ROWS[i].cfg_sel);
      end
      send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].py, DIR_ROWS[i].known, DIR_ROWS[i].iters,
                 DIR_ROWS[i].esc);
    end

    // Random views: slow receiver, then slow sender, then full rate with one long hold
    while (sent < RANDOM_ITEMS) begin
      wait_for_results();
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 7;
        recv_idle_pct <= 85;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct <= 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_arm <= 1'b1;
      end
      load_plane(random_plane());
      n = $urandom_range(48, 16);
      repeat (n) begin
        send_pixel(near_pixel(cur_mid_x, cur_step_x), near_pixel(cur_mid_y, cur_step_y),
                   1'b0, '0, 1'b0);
      end
      sent += n;
    end

    // Drain, then give stray results time to show up
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("mandelbrot_escape_time: match");
    else $display("mandelbrot_escape_time: mismatch");
    $finish;
  end

endmodule
